// ===== rtl/ipc_pkg.sv =====
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared codes, widths and types of the interrupt priority controller.
// ----------------------------------------------------------------------------
package ipc_pkg;

    // Default sizes of the controller.
    localparam int MASKABLE_MAX_DEFAULT   = 21;
    localparam int SOFTWARE_COUNT_DEFAULT = 64;

    // Field widths.
    localparam int ACTION_W = 4;
    localparam int LANE_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int SRC_W    = 6;
    localparam int LEVEL_W  = 2;
    localparam int KIND_W   = 3;
    localparam int COUNT_W  = 5;
    localparam int CFG_IDX_W = 1;

    // Register padded to four byte lanes for reads and writes.
    localparam int LANES_W = 32;

    // Reset value of the source count register.
    localparam logic [COUNT_W-1:0] SOURCE_COUNT_RESET = 5'd12;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NMI_WRITABLE = 1'd1;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_ACCEPT       = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE_MASK   = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_WRITE_PEND   = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_READ_MASK    = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_READ_PEND    = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_RAISE_MASK   = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_RAISE_SW     = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_BREAK        = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_EMULATOR     = 4'd8;
    localparam logic [ACTION_W-1:0] ACT_REQUEST_NMI  = 4'd9;
    localparam logic [ACTION_W-1:0] ACT_RESET        = 4'd10;

    // Kind codes of an accepted interrupt.
    localparam logic [KIND_W-1:0] KIND_RESET    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SOFTWARE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EMULATOR = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BREAK    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NMI      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_MASKABLE = 3'd5;

    // Exception levels entered.
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_IRQ   = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_EXC   = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_EMU   = 2'd3;

    // One input transaction.
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [LANE_W-1:0]   byte_offset;
        logic [BYTE_W-1:0]   write_data;
        logic [SRC_W-1:0]    source;
        logic [LEVEL_W-1:0]  cpu_level;
        logic                master_enable;
        logic                maskable_blocked;
    } item_t;

    // One result transaction.
    typedef struct packed {
        logic                taken;
        logic [KIND_W-1:0]   kind;
        logic [SRC_W-1:0]    taken_source;
        logic [LEVEL_W-1:0]  new_level;
        logic [BYTE_W-1:0]   read_data;
        logic                chip_reset;
        logic                any_active;
    } result_t;

    // Configuration write toward the core.
    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [COUNT_W-1:0]   data;
    } cfg_write_t;

endpackage

// ===== rtl/ipc_lowest_bit.sv =====
// ----------------------------------------------------------------------------
// ipc_lowest_bit
// Index of the lowest set bit of a vector; zero when no bit is set.
// ----------------------------------------------------------------------------
module ipc_lowest_bit #(
    parameter int WIDTH = 64,
    parameter int IDX_W = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
    input  logic [WIDTH-1:0] value,
    output logic [IDX_W-1:0] index
);

    logic [WIDTH-1:0] onehot;

    // Isolate the lowest set bit, then encode its position.
    assign onehot = value & (~value + WIDTH'(1));

    always_comb
    begin
        index = '0;
        for (int i = 0; i < WIDTH; i++)
        begin
            if (onehot[i])
            begin
                index = index | IDX_W'(i);
            end
        end
    end

endmodule

// ===== rtl/ipc_core.sv =====
// ----------------------------------------------------------------------------
// ipc_core
// Interrupt state, register access and the priority decision for one
// transaction per cycle; the state advances only on cycles with step high.
// ----------------------------------------------------------------------------
module ipc_core #(
    parameter int MASKABLE_MAX   = ipc_pkg::MASKABLE_MAX_DEFAULT,
    parameter int SOFTWARE_COUNT = ipc_pkg::SOFTWARE_COUNT_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  ipc_pkg::item_t      item,
    input  ipc_pkg::cfg_write_t cfg,
    output ipc_pkg::result_t    result
);

    localparam int REG_W  = MASKABLE_MAX + 1;
    localparam int SW_W   = SOFTWARE_COUNT;
    localparam int SW_IDX = (SW_W > 1) ? $clog2(SW_W) : 1;
    localparam int MK_IDX = (REG_W > 1) ? $clog2(REG_W) : 1;

    logic [ipc_pkg::COUNT_W-1:0] source_count_reg;
    logic                        nmi_writable_reg;

    logic [REG_W-1:0] mask_reg,     mask_next;
    logic [REG_W-1:0] pending_reg,  pending_next;
    logic             reset_flag_reg, reset_flag_next;
    logic             break_flag_reg, break_flag_next;
    logic             emu_flag_reg,   emu_flag_next;
    logic [SW_W-1:0]  sw_flags_reg,   sw_flags_next;

    logic [ipc_pkg::COUNT_W-1:0] count_eff;
    logic [REG_W-1:0]            in_use;
    logic [REG_W-1:0]            writable;
    logic [REG_W-1:0]            mask_active;
    logic [SW_IDX-1:0]           sw_index;
    logic [MK_IDX-1:0]           mk_index;
    logic [ipc_pkg::LANES_W-1:0] lane_mask;
    logic [ipc_pkg::LANES_W-1:0] lane_data;
    logic [ipc_pkg::LANES_W-1:0] mask_wide;
    logic [ipc_pkg::LANES_W-1:0] pending_wide;

    // Counts above the implemented width act as the largest one.
    assign count_eff = (source_count_reg > ipc_pkg::COUNT_W'(MASKABLE_MAX))
                     ? ipc_pkg::COUNT_W'(MASKABLE_MAX) : source_count_reg;

    always_comb
    begin
        for (int i = 0; i < REG_W; i++)
        begin
            in_use[i] = (i != 0) && (6'(i) <= {1'b0, count_eff});
        end
    end

    assign writable    = in_use | REG_W'(nmi_writable_reg);
    assign mask_active = mask_reg & pending_reg & in_use;

    assign mask_wide    = ipc_pkg::LANES_W'(mask_reg);
    assign pending_wide = ipc_pkg::LANES_W'(pending_reg);
    assign lane_mask    = ipc_pkg::LANES_W'(8'hFF) << {item.byte_offset, 3'b000};
    assign lane_data    = ipc_pkg::LANES_W'(item.write_data) << {item.byte_offset, 3'b000};

    ipc_lowest_bit #(
        .WIDTH (SW_W),
        .IDX_W (SW_IDX)
    ) u_sw_pick (
        .value (sw_flags_reg),
        .index (sw_index)
    );

    ipc_lowest_bit #(
        .WIDTH (REG_W),
        .IDX_W (MK_IDX)
    ) u_mask_pick (
        .value (mask_active),
        .index (mk_index)
    );

    always_comb
    begin
        logic clear_all;
        logic [ipc_pkg::LANES_W-1:0] wr_value;

        clear_all       = 1'b0;
        wr_value        = '0;
        mask_next       = mask_reg;
        pending_next    = pending_reg;
        reset_flag_next = reset_flag_reg;
        break_flag_next = break_flag_reg;
        emu_flag_next   = emu_flag_reg;
        sw_flags_next   = sw_flags_reg;
        result          = '0;

        unique case (item.action)
            ipc_pkg::ACT_ACCEPT:
            begin
                if (reset_flag_reg)
                begin
                    reset_flag_next  = 1'b0;
                    result.taken     = 1'b1;
                    result.kind      = ipc_pkg::KIND_RESET;
                    result.new_level = ipc_pkg::LEVEL_RESET;
                end
                else if (|sw_flags_reg)
                begin
                    sw_flags_next       = sw_flags_reg & ~(SW_W'(1) << sw_index);
                    result.taken        = 1'b1;
                    result.kind         = ipc_pkg::KIND_SOFTWARE;
                    result.taken_source = ipc_pkg::SRC_W'(sw_index);
                    result.new_level    = ipc_pkg::LEVEL_IRQ;
                end
                else if (emu_flag_reg)
                begin
                    emu_flag_next    = 1'b0;
                    result.taken     = 1'b1;
                    result.kind      = ipc_pkg::KIND_EMULATOR;
                    result.new_level = ipc_pkg::LEVEL_EMU;
                end
                else if (break_flag_reg)
                begin
                    break_flag_next  = 1'b0;
                    result.taken     = 1'b1;
                    result.kind      = ipc_pkg::KIND_BREAK;
                    result.new_level = ipc_pkg::LEVEL_EXC;
                end
                else if (mask_reg[0] && pending_reg[0])
                begin
                    // An NMI is refused only at the emulator level.
                    if (item.cpu_level != ipc_pkg::LEVEL_EMU)
                    begin
                        pending_next[0]  = 1'b0;
                        result.taken     = 1'b1;
                        result.kind      = ipc_pkg::KIND_NMI;
                        result.new_level = ipc_pkg::LEVEL_EXC;
                    end
                end
                else if (|mask_active)
                begin
                    if ((item.cpu_level <= ipc_pkg::LEVEL_IRQ) &&
                        item.master_enable && !item.maskable_blocked)
                    begin
                        pending_next        = pending_reg & ~(REG_W'(1) << mk_index);
                        result.taken        = 1'b1;
                        result.kind         = ipc_pkg::KIND_MASKABLE;
                        result.taken_source = ipc_pkg::SRC_W'(mk_index) - 6'd1;
                        result.new_level    = ipc_pkg::LEVEL_IRQ;
                    end
                end
            end
            ipc_pkg::ACT_WRITE_MASK:
            begin
                wr_value  = (mask_wide & ~lane_mask) | lane_data;
                mask_next = wr_value[REG_W-1:0] & writable;
            end
            ipc_pkg::ACT_WRITE_PEND:
            begin
                wr_value     = (pending_wide & ~lane_mask) | lane_data;
                pending_next = wr_value[REG_W-1:0] & writable;
            end
            ipc_pkg::ACT_READ_MASK:
            begin
                result.read_data = ipc_pkg::BYTE_W'(mask_wide >> {item.byte_offset, 3'b000});
            end
            ipc_pkg::ACT_READ_PEND:
            begin
                result.read_data = ipc_pkg::BYTE_W'(pending_wide >> {item.byte_offset, 3'b000});
            end
            ipc_pkg::ACT_RAISE_MASK:
            begin
                if (item.source < ipc_pkg::SRC_W'(count_eff))
                begin
                    pending_next = pending_reg | (REG_W'(1) << (7'(item.source) + 7'd1));
                end
            end
            ipc_pkg::ACT_RAISE_SW:
            begin
                if (7'(item.source) < 7'(SOFTWARE_COUNT))
                begin
                    sw_flags_next = sw_flags_reg | (SW_W'(1) << item.source);
                end
            end
            ipc_pkg::ACT_BREAK:
            begin
                if (item.cpu_level > ipc_pkg::LEVEL_IRQ)
                begin
                    clear_all         = 1'b1;
                    result.chip_reset = 1'b1;
                end
                else
                begin
                    break_flag_next = 1'b1;
                end
            end
            ipc_pkg::ACT_EMULATOR:
            begin
                emu_flag_next = 1'b1;
            end
            ipc_pkg::ACT_REQUEST_NMI:
            begin
                pending_next[0] = 1'b1;
            end
            ipc_pkg::ACT_RESET:
            begin
                clear_all = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (clear_all)
        begin
            mask_next       = '0;
            pending_next    = '0;
            reset_flag_next = 1'b1;
            break_flag_next = 1'b0;
            emu_flag_next   = 1'b0;
            sw_flags_next   = '0;
        end

        // The activity summary looks at the state left by this transaction.
        result.any_active = reset_flag_next || (|sw_flags_next) || emu_flag_next ||
                            break_flag_next ||
                            (|(mask_next & pending_next & (in_use | REG_W'(1))));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_count_reg <= ipc_pkg::SOURCE_COUNT_RESET;
            nmi_writable_reg <= 1'b0;
        end
        else if (cfg.we)
        begin
            unique case (cfg.index)
                ipc_pkg::CFG_SOURCE_COUNT: source_count_reg <= cfg.data;
                ipc_pkg::CFG_NMI_WRITABLE: nmi_writable_reg <= cfg.data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg       <= '0;
            pending_reg    <= '0;
            reset_flag_reg <= 1'b1;
            break_flag_reg <= 1'b0;
            emu_flag_reg   <= 1'b0;
            sw_flags_reg   <= '0;
        end
        else if (step)
        begin
            mask_reg       <= mask_next;
            pending_reg    <= pending_next;
            reset_flag_reg <= reset_flag_next;
            break_flag_reg <= break_flag_next;
            emu_flag_reg   <= emu_flag_next;
            sw_flags_reg   <= sw_flags_next;
        end
    end

endmodule

// ===== rtl/interrupt_priority_controller.sv =====
// ----------------------------------------------------------------------------
// interrupt_priority_controller
// Priority interrupt controller with exception levels and byte-wide access
// to its mask and pending registers.
//
// Flow: the accepting edge loads the input register, and a step of the core
// then loads the result register, which offers the result from then on.
// Throughput: one transaction per cycle while the result side is ready; the
// whole decision is one pass of logic between the two registers.
// Reset: rst_n clears both registers' valid bits and loads the reset flag,
// so the first accept tick after reset reports a reset entry.
// ----------------------------------------------------------------------------
module interrupt_priority_controller #(
    parameter int MASKABLE_MAX   = ipc_pkg::MASKABLE_MAX_DEFAULT,
    parameter int SOFTWARE_COUNT = ipc_pkg::SOFTWARE_COUNT_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // Input channel.
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ipc_pkg::ACTION_W-1:0]    action,
    input  logic [ipc_pkg::LANE_W-1:0]      byte_offset,
    input  logic [ipc_pkg::BYTE_W-1:0]      write_data,
    input  logic [ipc_pkg::SRC_W-1:0]       source,
    input  logic [ipc_pkg::LEVEL_W-1:0]     cpu_level,
    input  logic                            master_enable,
    input  logic                            maskable_blocked,

    // Result channel.
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            taken,
    output logic [ipc_pkg::KIND_W-1:0]      kind,
    output logic [ipc_pkg::SRC_W-1:0]       taken_source,
    output logic [ipc_pkg::LEVEL_W-1:0]     new_level,
    output logic [ipc_pkg::BYTE_W-1:0]      read_data,
    output logic                            chip_reset,
    output logic                            any_active,

    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ipc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ipc_pkg::COUNT_W-1:0]     cfg_data
);

    // The input register holds one accepted transaction until the core has
    // processed it. The core processes it in the cycle after acceptance,
    // provided the result register is empty or is being emptied.
    logic                in_hold_reg;
    ipc_pkg::item_t      item_reg;
    logic                out_valid_reg;
    ipc_pkg::result_t    result_reg;
    ipc_pkg::result_t    result_next;
    ipc_pkg::cfg_write_t cfg_write;
    logic                step;
    logic                in_fire;

    assign step     = in_hold_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_hold_reg || step;
    assign in_fire  = in_valid && in_ready;

    // Config writes are always taken; users must write only while idle.
    assign cfg_ready       = 1'b1;
    assign cfg_write.we    = cfg_valid;
    assign cfg_write.index = cfg_index;
    assign cfg_write.data  = cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_hold_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            in_hold_reg <= 1'b1;
        end
        else if (step)
        begin
            in_hold_reg <= 1'b0;
        end
    end

    // Payload capture needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.action           <= action;
            item_reg.byte_offset      <= byte_offset;
            item_reg.write_data       <= write_data;
            item_reg.source           <= source;
            item_reg.cpu_level        <= cpu_level;
            item_reg.master_enable    <= master_enable;
            item_reg.maskable_blocked <= maskable_blocked;
        end
    end

    // All interrupt state and the priority decision live in the core. It
    // updates its state only on a step, so transactions take effect in order.
    ipc_core #(
        .MASKABLE_MAX   (MASKABLE_MAX),
        .SOFTWARE_COUNT (SOFTWARE_COUNT)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .cfg    (cfg_write),
        .result (result_next)
    );

    // The result register decouples the result side, so a new input
    // transaction is accepted while a finished result still waits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign taken        = result_reg.taken;
    assign kind         = result_reg.kind;
    assign taken_source = result_reg.taken_source;
    assign new_level    = result_reg.new_level;
    assign read_data    = result_reg.read_data;
    assign chip_reset   = result_reg.chip_reset;
    assign any_active   = result_reg.any_active;

endmodule

// ===== bench/interrupt_priority_controller_test.sv =====
// ----------------------------------------------------------------------------
// interrupt_priority_controller_test
// Self-checking bench for the priority interrupt controller. A short list of
// directed transactions covers the corners of the register file and of the
// accept priority; weighted random traffic then runs under several settings
// of the configuration registers. Every result is checked field by field
// against a predictor kept inside the bench, or a result typed into the list.
// ----------------------------------------------------------------------------
module interrupt_priority_controller_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Width of the mask and pending registers: the NMI bit plus every source.
    localparam int REG_W = ipc_pkg::MASKABLE_MAX_DEFAULT + 1;

    // Highest action code; everything above ACT_RESET does nothing.
    localparam logic [ipc_pkg::ACTION_W-1:0] ACT_SPARE_TOP = 4'd15;

    // Cycles in a row with no handshake on any channel before the run gives up.
    localparam int QUIET_LIMIT = 2000;

    // Random transactions per configuration phase.
    localparam int PHASE_ITEMS = 80;
    localparam int PHASES      = 6;

    // One line of the directed list: either a transaction, with or without a
    // result typed in by hand, or a configuration write.
    typedef struct packed {
        logic                          cfg_row;
        logic                          typed;
        ipc_pkg::item_t                it;
        ipc_pkg::result_t              res;
        logic [ipc_pkg::CFG_IDX_W-1:0] cfg_idx;
        logic [ipc_pkg::COUNT_W-1:0]   cfg_val;
    } step_t;

    logic clk;
    logic rst_n;

    logic                          in_valid;
    logic                          in_ready;
    logic [ipc_pkg::ACTION_W-1:0]  action;
    logic [ipc_pkg::LANE_W-1:0]    byte_offset;
    logic [ipc_pkg::BYTE_W-1:0]    write_data;
    logic [ipc_pkg::SRC_W-1:0]     source;
    logic [ipc_pkg::LEVEL_W-1:0]   cpu_level;
    logic                          master_enable;
    logic                          maskable_blocked;

    logic                          out_valid;
    logic                          out_ready;
    logic                          taken;
    logic [ipc_pkg::KIND_W-1:0]    kind;
    logic [ipc_pkg::SRC_W-1:0]     taken_source;
    logic [ipc_pkg::LEVEL_W-1:0]   new_level;
    logic [ipc_pkg::BYTE_W-1:0]    read_data;
    logic                          chip_reset;
    logic                          any_active;

    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [ipc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ipc_pkg::COUNT_W-1:0]   cfg_data;

    // Hand-written expectation that travels with the transaction on the bus.
    logic             typed_now;
    ipc_pkg::result_t typed_result;

    // Set for the last phase: no gaps on the sender, no stalls on the receiver.
    bit calm;

    // Results the controller still owes us, oldest first.
    ipc_pkg::result_t results_due[$];
    int               mismatches;

    // Predictor copy of the controller state and its configuration.
    logic [REG_W-1:0]            mask_model;
    logic [REG_W-1:0]            pend_model;
    logic                        reset_req;
    logic                        break_req;
    logic                        emu_req;
    logic [63:0]                 soft_req;
    logic [ipc_pkg::COUNT_W-1:0] count_model;
    logic                        nmi_wr_model;

    interrupt_priority_controller u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .action           (action),
        .byte_offset      (byte_offset),
        .write_data       (write_data),
        .source           (source),
        .cpu_level        (cpu_level),
        .master_enable    (master_enable),
        .maskable_blocked (maskable_blocked),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .taken            (taken),
        .kind             (kind),
        .taken_source     (taken_source),
        .new_level        (new_level),
        .read_data        (read_data),
        .chip_reset       (chip_reset),
        .any_active       (any_active),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // 12 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Number of maskable sources actually in use; larger settings saturate.
    function automatic int sources_in_use();
        return (count_model > ipc_pkg::MASKABLE_MAX_DEFAULT)
               ? ipc_pkg::MASKABLE_MAX_DEFAULT : int'(count_model);
    endfunction

    // Bits of mask and pending that software writes can reach. The NMI bit
    // only survives a write when the configuration allows it.
    function automatic logic [63:0] writable_bits();
        logic [63:0] top;
        logic [63:0] full;
        top  = 64'd1 << (sources_in_use() + 1);
        full = (64'd1 << REG_W) - 64'd1;
        return (top - (nmi_wr_model ? 64'd1 : 64'd2)) & full;
    endfunction

    // Maskable positions (bits 1..count) that can become active.
    function automatic logic [63:0] maskable_bits();
        return ((64'd1 << (sources_in_use() + 1)) - 64'd1) & ~64'd1;
    endfunction

    function automatic int lowest_set(logic [63:0] v);
        for (int n = 0; n < 64; n++)
        begin
            if (v[n])
                return n;
        end
        return 63;
    endfunction

    function automatic logic [REG_W-1:0] lane_write(logic [REG_W-1:0] cur,
                                                   logic [ipc_pkg::LANE_W-1:0] lane,
                                                   logic [ipc_pkg::BYTE_W-1:0] data);
        logic [63:0] v;
        int          sh;
        sh = int'(lane) * 8;
        v  = '0;
        v[REG_W-1:0] = cur;
        v  = (v & ~(64'hFF << sh)) | (64'(data) << sh);
        v  = v & writable_bits();
        return v[REG_W-1:0];
    endfunction

    function automatic logic [ipc_pkg::BYTE_W-1:0] lane_read(logic [REG_W-1:0] cur,
                                                            logic [ipc_pkg::LANE_W-1:0] lane);
        logic [63:0] v;
        v = '0;
        v[REG_W-1:0] = cur;
        v = v >> (int'(lane) * 8);
        return v[ipc_pkg::BYTE_W-1:0];
    endfunction

    // A chip reset wipes the interrupt state but keeps the configuration.
    task automatic wipe_interrupt_state();
        mask_model = '0;
        pend_model = '0;
        reset_req  = 1'b1;
        break_req  = 1'b0;
        emu_req    = 1'b0;
        soft_req   = '0;
    endtask

    // Applies one transaction to the predictor state and works out the result
    // the controller has to return for it.
    task automatic decide_interrupt(input ipc_pkg::item_t it, output ipc_pkg::result_t r);
        logic [63:0] live;
        int          b;
        r = '0;
        case (it.action)
            ipc_pkg::ACT_ACCEPT:
            begin
                live = 64'(mask_model & pend_model) & maskable_bits();
                // Fixed priority. A refused NMI or maskable source blocks
                // everything below it on this tick.
                if (reset_req)
                begin
                    reset_req   = 1'b0;
                    r.taken     = 1'b1;
                    r.kind      = ipc_pkg::KIND_RESET;
                    r.new_level = ipc_pkg::LEVEL_RESET;
                end
                else if (soft_req != '0)
                begin
                    b           = lowest_set(soft_req);
                    soft_req[b] = 1'b0;
                    r.taken        = 1'b1;
                    r.kind         = ipc_pkg::KIND_SOFTWARE;
                    r.taken_source = ipc_pkg::SRC_W'(b);
                    r.new_level    = ipc_pkg::LEVEL_IRQ;
                end
                else if (emu_req)
                begin
                    emu_req     = 1'b0;
                    r.taken     = 1'b1;
                    r.kind      = ipc_pkg::KIND_EMULATOR;
                    r.new_level = ipc_pkg::LEVEL_EMU;
                end
                else if (break_req)
                begin
                    break_req   = 1'b0;
                    r.taken     = 1'b1;
                    r.kind      = ipc_pkg::KIND_BREAK;
                    r.new_level = ipc_pkg::LEVEL_EXC;
                end
                else if (mask_model[0] && pend_model[0])
                begin
                    if (it.cpu_level <= ipc_pkg::LEVEL_EXC)
                    begin
                        pend_model[0] = 1'b0;
                        r.taken       = 1'b1;
                        r.kind        = ipc_pkg::KIND_NMI;
                        r.new_level   = ipc_pkg::LEVEL_EXC;
                    end
                end
                else if (live != '0)
                begin
                    b = lowest_set(live);
                    if (it.cpu_level <= ipc_pkg::LEVEL_IRQ && it.master_enable &&
                        !it.maskable_blocked)
                    begin
                        pend_model[b]  = 1'b0;
                        r.taken        = 1'b1;
                        r.kind         = ipc_pkg::KIND_MASKABLE;
                        r.taken_source = ipc_pkg::SRC_W'(b - 1);
                        r.new_level    = ipc_pkg::LEVEL_IRQ;
                    end
                end
            end
            ipc_pkg::ACT_WRITE_MASK:
                mask_model = lane_write(mask_model, it.byte_offset, it.write_data);
            ipc_pkg::ACT_WRITE_PEND:
                pend_model = lane_write(pend_model, it.byte_offset, it.write_data);
            ipc_pkg::ACT_READ_MASK:
                r.read_data = lane_read(mask_model, it.byte_offset);
            ipc_pkg::ACT_READ_PEND:
                r.read_data = lane_read(pend_model, it.byte_offset);
            ipc_pkg::ACT_RAISE_MASK:
            begin
                if (int'(it.source) < sources_in_use())
                    pend_model[int'(it.source) + 1] = 1'b1;
            end
            ipc_pkg::ACT_RAISE_SW:    soft_req[it.source] = 1'b1;
            ipc_pkg::ACT_BREAK:
            begin
                // A break taken while already in an exception resets the chip.
                if (it.cpu_level > ipc_pkg::LEVEL_IRQ)
                begin
                    wipe_interrupt_state();
                    r.chip_reset = 1'b1;
                end
                else
                    break_req = 1'b1;
            end
            ipc_pkg::ACT_EMULATOR:    emu_req = 1'b1;
            ipc_pkg::ACT_REQUEST_NMI: pend_model[0] = 1'b1;
            ipc_pkg::ACT_RESET:       wipe_interrupt_state();
            default: ;
        endcase
        r.any_active = reset_req || (soft_req != '0) || emu_req || break_req ||
                       (mask_model[0] && pend_model[0]) ||
                       ((64'(mask_model & pend_model) & maskable_bits()) != '0);
    endtask

    // ------------------------------------------------------------------------
    // Monitor: configuration writes, accepted transactions and results are all
    // sampled at the rising edge, in that order, so the predictor sees them in
    // the same sequence as the controller.
    // ------------------------------------------------------------------------

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        ipc_pkg::item_t   seen;
        ipc_pkg::result_t guess;
        ipc_pkg::result_t want;
        if (rst_n && cfg_valid && cfg_ready)
        begin
            if (cfg_index == ipc_pkg::CFG_SOURCE_COUNT)
                count_model = cfg_data;
            else
                nmi_wr_model = cfg_data[0];
        end
        if (rst_n && in_valid && in_ready)
        begin
            seen.action           = action;
            seen.byte_offset      = byte_offset;
            seen.write_data       = write_data;
            seen.source           = source;
            seen.cpu_level        = cpu_level;
            seen.master_enable    = master_enable;
            seen.maskable_blocked = maskable_blocked;
            decide_interrupt(seen, guess);
            // A result typed into the directed list overrides the predictor,
            // which still has to track the state change.
            results_due.push_back(typed_now ? typed_result : guess);
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (results_due.size() == 0)
            begin
                $error("result transaction arrived with nothing outstanding");
                mismatches++;
            end
            else
            begin
                want = results_due.pop_front();
                check_field("taken",        want.taken,        taken);
                check_field("kind",         want.kind,         kind);
                check_field("taken_source", want.taken_source, taken_source);
                check_field("new_level",    want.new_level,    new_level);
                check_field("read_data",    want.read_data,    read_data);
                check_field("chip_reset",   want.chip_reset,   chip_reset);
                check_field("any_active",   want.any_active,   any_active);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: out_ready runs high for a while, then drops for a random burst.
    // In the calm phase it stays high.
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm)
                out_ready = 1'b1;
            else if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                out_ready  = 1'b0;
                stall_left = int'($urandom_range(1, 17)) - 1;
            end
            else
                out_ready = 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: the run is stuck if nothing moves on any channel for too long.
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender tasks. Inputs only change at the falling edge.
    // ------------------------------------------------------------------------

    // Presents one transaction after an optional gap and holds it until the
    // controller takes it. in_valid stays high between back-to-back items.
    task automatic send_item(ipc_pkg::item_t it, int gap, logic typed,
                             ipc_pkg::result_t res);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        action           = it.action;
        byte_offset      = it.byte_offset;
        write_data       = it.write_data;
        source           = it.source;
        cpu_level        = it.cpu_level;
        master_enable    = it.master_enable;
        maskable_blocked = it.maskable_blocked;
        typed_now        = typed;
        typed_result     = res;
        in_valid         = 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stops sending and waits until every outstanding result has come back.
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    // Configuration is only written with the controller idle: drain, let the
    // two-stage pipeline settle, then issue the write.
    task automatic write_register(logic [ipc_pkg::CFG_IDX_W-1:0] idx,
                                  logic [ipc_pkg::COUNT_W-1:0] val);
        drain_results();
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic int random_gap();
        if (calm || $urandom_range(0, 4) != 0)
            return 0;
        return $urandom_range(1, 17);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------

    function automatic ipc_pkg::item_t op(logic [ipc_pkg::ACTION_W-1:0] act,
                                          logic [ipc_pkg::LANE_W-1:0] lane,
                                          logic [ipc_pkg::BYTE_W-1:0] data,
                                          logic [ipc_pkg::SRC_W-1:0] src,
                                          logic [ipc_pkg::LEVEL_W-1:0] lvl,
                                          logic en, logic blk);
        ipc_pkg::item_t it;
        it.action           = act;
        it.byte_offset      = lane;
        it.write_data       = data;
        it.source           = src;
        it.cpu_level        = lvl;
        it.master_enable    = en;
        it.maskable_blocked = blk;
        return it;
    endfunction

    function automatic ipc_pkg::result_t outcome(logic tk, logic [ipc_pkg::KIND_W-1:0] kd,
                                                 logic [ipc_pkg::SRC_W-1:0] src,
                                                 logic [ipc_pkg::LEVEL_W-1:0] lvl,
                                                 logic [ipc_pkg::BYTE_W-1:0] rd,
                                                 logic crst, logic act);
        ipc_pkg::result_t r;
        r.taken        = tk;
        r.kind         = kd;
        r.taken_source = src;
        r.new_level    = lvl;
        r.read_data    = rd;
        r.chip_reset   = crst;
        r.any_active   = act;
        return r;
    endfunction

    function automatic step_t predicted(ipc_pkg::item_t it);
        step_t s;
        s    = '0;
        s.it = it;
        return s;
    endfunction

    function automatic step_t known(ipc_pkg::item_t it, ipc_pkg::result_t r);
        step_t s;
        s       = '0;
        s.typed = 1'b1;
        s.it    = it;
        s.res   = r;
        return s;
    endfunction

    function automatic step_t cfg_step(logic [ipc_pkg::CFG_IDX_W-1:0] idx,
                                       logic [ipc_pkg::COUNT_W-1:0] val);
        step_t s;
        s         = '0;
        s.cfg_row = 1'b1;
        s.cfg_idx = idx;
        s.cfg_val = val;
        return s;
    endfunction

    // Weighted random transaction. Accept ticks, mask writes and raises
    // dominate so that sources actually become active and get taken; breaks
    // and resets are kept rare since they wipe the state.
    function automatic ipc_pkg::item_t random_item();
        ipc_pkg::item_t it;
        int unsigned    pick;
        it.byte_offset      = ipc_pkg::LANE_W'($urandom_range(0, 3));
        it.write_data       = ipc_pkg::BYTE_W'($urandom_range(0, 255));
        it.source           = ipc_pkg::SRC_W'($urandom_range(0, 63));
        it.cpu_level        = ipc_pkg::LEVEL_W'($urandom_range(0, 3));
        it.master_enable    = ($urandom_range(0, 9) != 0);
        it.maskable_blocked = ($urandom_range(0, 9) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 33)
        begin
            it.action = ipc_pkg::ACT_ACCEPT;
            if ($urandom_range(0, 4) != 0)
                it.cpu_level = ipc_pkg::LEVEL_W'($urandom_range(0, 1));
        end
        else if (pick < 45)
        begin
            it.action = ipc_pkg::ACT_WRITE_MASK;
            if ($urandom_range(0, 1) != 0)
                it.write_data = 8'hFF;
        end
        else if (pick < 53)
            it.action = ipc_pkg::ACT_WRITE_PEND;
        else if (pick < 58)
            it.action = ipc_pkg::ACT_READ_MASK;
        else if (pick < 63)
            it.action = ipc_pkg::ACT_READ_PEND;
        else if (pick < 78)
        begin
            it.action = ipc_pkg::ACT_RAISE_MASK;
            if ($urandom_range(0, 6) != 0)
                it.source = ipc_pkg::SRC_W'($urandom_range(0,
                                                           ipc_pkg::MASKABLE_MAX_DEFAULT + 1));
        end
        else if (pick < 84)
            it.action = ipc_pkg::ACT_RAISE_SW;
        else if (pick < 87)
            it.action = ipc_pkg::ACT_BREAK;
        else if (pick < 91)
            it.action = ipc_pkg::ACT_EMULATOR;
        else if (pick < 96)
            it.action = ipc_pkg::ACT_REQUEST_NMI;
        else if (pick < 98)
            it.action = ipc_pkg::ACT_RESET;
        else
            it.action = ipc_pkg::ACTION_W'($urandom_range(int'(ipc_pkg::ACT_RESET) + 1,
                                                          int'(ACT_SPARE_TOP)));
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        step_t                       plan[$];
        ipc_pkg::result_t            quiet_res;
        logic [ipc_pkg::COUNT_W-1:0] phase_count[PHASES];
        logic                        phase_nmi[PHASES];

        // Every input known from time zero.
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        action           = ipc_pkg::ACT_ACCEPT;
        byte_offset      = '0;
        write_data       = '0;
        source           = '0;
        cpu_level        = '0;
        master_enable    = 1'b0;
        maskable_blocked = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = ipc_pkg::CFG_SOURCE_COUNT;
        cfg_data         = '0;
        typed_now        = 1'b0;
        typed_result     = '0;
        calm             = 1'b0;
        mismatches       = 0;

        // Predictor starts from the reset state of the controller.
        count_model  = ipc_pkg::SOURCE_COUNT_RESET;
        nmi_wr_model = 1'b0;
        wipe_interrupt_state();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        quiet_res = '0;

        // Directed list, run with the reset configuration (12 sources, NMI
        // bit not writable) until the configuration row part way down.
        // The first tick after reset must report a reset entry.
        plan.push_back(known(op(ipc_pkg::ACT_ACCEPT, 0, 0, 0, 0, 1, 0),
                             outcome(1, ipc_pkg::KIND_RESET, 0, ipc_pkg::LEVEL_RESET,
                                     0, 0, 0)));
        // Full-byte mask writes: bit 0 and bits above bit 12 are dropped,
        // and lane 3 lies entirely outside the register.
        plan.push_back(known(op(ipc_pkg::ACT_WRITE_MASK, 0, 8'hFF, 0, 0, 0, 0), quiet_res));
        plan.push_back(known(op(ipc_pkg::ACT_WRITE_MASK, 1, 8'hFF, 0, 0, 0, 0), quiet_res));
        plan.push_back(known(op(ipc_pkg::ACT_WRITE_MASK, 3, 8'hFF, 0, 0, 0, 0), quiet_res));
        plan.push_back(known(op(ipc_pkg::ACT_READ_MASK, 0, 0, 0, 0, 0, 0),
                             outcome(0, ipc_pkg::KIND_RESET, 0, ipc_pkg::LEVEL_RESET,
                                     8'hFE, 0, 0)));
        plan.push_back(known(op(ipc_pkg::ACT_READ_MASK, 3, 0, 0, 0, 0, 0), quiet_res));
        // Raising a source beyond the count is ignored; so is a spare action.
        plan.push_back(known(op(ipc_pkg::ACT_RAISE_MASK, 0, 0, 6'h3F, 0, 0, 0), quiet_res));
        plan.push_back(known(op(ACT_SPARE_TOP, 3, 8'hFF, 6'h3F, 3, 1, 1), quiet_res));
        // Maskable source 0 refused while blocked and above level 1, then taken.
        plan.push_back(predicted(op(ipc_pkg::ACT_RAISE_MASK, 0, 0, 0, 0, 0, 0)));
        plan.push_back(predicted(op(ipc_pkg::ACT_ACCEPT, 0, 0, 0, 0, 1, 1)));
        plan.push_back(predicted(op(ipc_pkg::ACT_ACCEPT, 0, 0, 0, 2, 1, 0)));
        plan.push_back(predicted(op(ipc_pkg::ACT_ACCEPT, 0, 0, 0, 1, 1, 0)));
        // Software interrupts, emulator and an NMI request. The NMI stays
        // inactive because its mask bit could not be written.
        plan.push_back(predicted(op(ipc_pkg::ACT_RAISE_SW, 0, 0, 6'h3F, 0, 0, 0)));
        plan.push_back(predicted(op(ipc_pkg::ACT_RAISE_SW, 0, 0, 0, 0, 0, 0)));
        plan.push_back(predicted(op(ipc_pkg::ACT_EMULATOR, 0, 0, 0, 0, 0, 0)));
        plan.push_back(predicted(op(ipc_pkg::ACT_REQUEST_NMI, 0, 0, 0, 0, 0, 0)));
        // Lowest software number first, then the other one, then emulator.
        plan.push_back(predicted(op(ipc_pkg::ACT_ACCEPT, 0, 0, 0, 0, 1, 0)));
        plan.push_back(predicted(op(ipc_pkg::ACT_ACCEPT, 0, 0, 0, 0, 1, 0)));
        plan.push_back(predicted(op(ipc_pkg::ACT_ACCEPT, 0, 0, 0, 0, 1, 0)));
        // Allow the NMI mask bit, unmask it, see it refused at level 3 and
        // taken at level 2.
        plan.push_back(cfg_step(ipc_pkg::CFG_NMI_WRITABLE, 1));
        plan.push_back(predicted(op(ipc_pkg::ACT_WRITE_MASK, 0, 8'h01, 0, 0, 0, 0)));
        plan.push_back(predicted(op(ipc_pkg::ACT_ACCEPT, 0, 0, 0, 3, 1, 0)));
        plan.push_back(predicted(op(ipc_pkg::ACT_ACCEPT, 0, 0, 0, 2, 1, 0)));
        // A break inside an exception resets the chip: everything cleared and
        // the reset flag raised again.
        plan.push_back(known(op(ipc_pkg::ACT_BREAK, 0, 0, 0, 2, 0, 0),
                             outcome(0, ipc_pkg::KIND_RESET, 0, ipc_pkg::LEVEL_RESET,
                                     0, 1, 1)));
        plan.push_back(known(op(ipc_pkg::ACT_READ_PEND, 0, 0, 0, 0, 0, 0),
                             outcome(0, ipc_pkg::KIND_RESET, 0, ipc_pkg::LEVEL_RESET,
                                     0, 0, 1)));
        plan.push_back(predicted(op(ipc_pkg::ACT_RESET, 0, 0, 0, 0, 0, 0)));
        plan.push_back(known(op(ipc_pkg::ACT_ACCEPT, 0, 0, 0, 3, 0, 1),
                             outcome(1, ipc_pkg::KIND_RESET, 0, ipc_pkg::LEVEL_RESET,
                                     0, 0, 0)));

        foreach (plan[k])
        begin
            if (plan[k].cfg_row)
                write_register(plan[k].cfg_idx, plan[k].cfg_val);
            else
                send_item(plan[k].it, random_gap(), plan[k].typed, plan[k].res);
        end

        // Random phases. Both registers are rewritten at each phase boundary,
        // covering the largest count, a single source, no sources at all,
        // an out-of-range count and a random one. The last phase runs with
        // no idling on either side.
        phase_count[0] = ipc_pkg::COUNT_W'(ipc_pkg::MASKABLE_MAX_DEFAULT);
        phase_nmi[0]   = 1'b1;
        phase_count[1] = ipc_pkg::COUNT_W'(1);
        phase_nmi[1]   = 1'b0;
        phase_count[2] = '0;
        phase_nmi[2]   = 1'b1;
        phase_count[3] = '1;
        phase_nmi[3]   = 1'b1;
        phase_count[4] = ipc_pkg::COUNT_W'($urandom_range(1, ipc_pkg::MASKABLE_MAX_DEFAULT));
        phase_nmi[4]   = 1'($urandom_range(0, 1));
        phase_count[5] = ipc_pkg::COUNT_W'(ipc_pkg::MASKABLE_MAX_DEFAULT);
        phase_nmi[5]   = 1'b0;

        for (int p = 0; p < PHASES; p++)
        begin
            write_register(ipc_pkg::CFG_SOURCE_COUNT, phase_count[p]);
            write_register(ipc_pkg::CFG_NMI_WRITABLE,
                           {{(ipc_pkg::COUNT_W-1){1'b0}}, phase_nmi[p]});
            if (p == PHASES - 1)
                calm = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // Now and then hold off until the pipeline is empty.
                if (!calm && $urandom_range(0, 59) == 0)
                    drain_results();
                send_item(random_item(), random_gap(), 1'b0, quiet_res);
            end
        end

        // Wind down: collect everything still in flight, then keep watching the
        // result side for any stray result.
        drain_results();
        repeat (8) @(posedge clk);

        if (mismatches == 0 && results_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== interrupt_priority_controller.f =====
rtl/ipc_pkg.sv
rtl/ipc_lowest_bit.sv
rtl/ipc_core.sv
rtl/interrupt_priority_controller.sv
bench/interrupt_priority_controller_test.sv
